FILE: rtl/atp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the autoscaled trace plotter.
package atp_pkg;

    localparam int WIDTH    = 64;
    localparam int AW       = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int CW       = $clog2(WIDTH + 1);

    localparam int SAMPLE_W = 8;
    localparam int ROW_W    = 6;
    localparam int LIMIT_W  = 9;
    localparam int DIFF_W   = 8;
    localparam int HEIGHT_W = ROW_W + 1;
    localparam int PROD_W   = 14;
    localparam int STEP_W   = 4;

    localparam int MUL_STEPS = ROW_W;
    localparam int DIV_STEPS = PROD_W;

    localparam logic signed [LIMIT_W-1:0] MIN_INIT = 9'sd255;
    localparam logic signed [LIMIT_W-1:0] MAX_INIT = -9'sd256;

    localparam logic [ROW_W-1:0] TOP_RESET    = 6'd10;
    localparam logic [ROW_W-1:0] BOTTOM_RESET = 6'd62;

    localparam logic REG_TOP_ROW    = 1'b0;
    localparam logic REG_BOTTOM_ROW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WIDEN,
        ST_READ,
        ST_LAUNCH,
        ST_CALC
    } t_ctl_state;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL,
        SC_PREP,
        SC_DIV,
        SC_DONE
    } t_scl_state;

endpackage

FILE: rtl/atp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module atp_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [DW-1:0]                    i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [DW-1:0]                    o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/atp_scaler.sv
`timescale 1ns / 1ps
// Bit-serial scaler: shift-add multiply, rounding bias, restoring divide, row offset.
module atp_scaler
    import atp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DIFF_W-1:0]          i_diff,
    input  logic signed [HEIGHT_W-1:0] i_height,
    input  logic [DIFF_W-1:0]          i_span,
    input  logic [ROW_W-1:0]           i_bottom,
    output logic                       o_done,
    output logic [ROW_W-1:0]           o_row
);

    t_scl_state r_state, n_state;

    logic [PROD_W-1:0]   r_mcand;
    logic [ROW_W-1:0]    r_mplier;
    logic [PROD_W-1:0]   r_acc;
    logic                r_hneg;
    logic                r_qneg;
    logic [DIFF_W-1:0]   r_span;
    logic [ROW_W-1:0]    r_bottom;
    logic [PROD_W-1:0]   r_num;
    logic [DIFF_W-1:0]   r_rem;
    logic [STEP_W-1:0]   r_cnt;

    logic [HEIGHT_W-1:0] w_habs;
    logic [PROD_W-1:0]   w_half;
    logic [DIFF_W:0]     w_shift;
    logic                w_qbit;
    logic                w_last_mul;
    logic                w_last_div;

    assign w_habs     = i_height[HEIGHT_W-1] ? HEIGHT_W'(-i_height) : HEIGHT_W'(i_height);
    assign w_half     = PROD_W'(r_span >> 1);
    assign w_shift    = {r_rem, r_num[PROD_W-1]};
    assign w_qbit     = (w_shift >= {1'b0, r_span});
    assign w_last_mul = (r_cnt == STEP_W'(MUL_STEPS - 1));
    assign w_last_div = (r_cnt == STEP_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SC_IDLE: if (i_start) n_state = SC_MUL;
            SC_MUL:  if (w_last_mul) n_state = SC_PREP;
            SC_PREP: n_state = SC_DIV;
            SC_DIV:  if (w_last_div) n_state = SC_DONE;
            SC_DONE: n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_comb begin
        o_done = 1'b0;
        o_row  = r_bottom;
        unique case (r_state)
            SC_DONE: begin
                o_done = 1'b1;
                o_row  = r_qneg ? r_bottom + r_num[ROW_W-1:0]
                                : r_bottom - r_num[ROW_W-1:0];
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    r_mcand  <= PROD_W'(i_diff);
                    r_mplier <= w_habs[ROW_W-1:0];
                    r_hneg   <= i_height[HEIGHT_W-1];
                    r_acc    <= '0;
                    r_span   <= i_span;
                    r_bottom <= i_bottom;
                    r_cnt    <= '0;
                end
            end
            SC_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
            end
            SC_PREP: begin
                // numerator = +/-product + span/2, split into sign and magnitude
                if (!r_hneg) begin
                    r_num  <= r_acc + w_half;
                    r_qneg <= 1'b0;
                end else if (r_acc >= w_half) begin
                    r_num  <= r_acc - w_half;
                    r_qneg <= 1'b1;
                end else begin
                    r_num  <= w_half - r_acc;
                    r_qneg <= 1'b0;
                end
                r_rem <= '0;
                r_cnt <= '0;
            end
            SC_DIV: begin
                r_rem <= w_qbit ? DIFF_W'(w_shift - {1'b0, r_span}) : w_shift[DIFF_W-1:0];
                r_num <= {r_num[PROD_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

FILE: rtl/autoscaled_trace_plotter.sv
`timescale 1ns / 1ps
// Top level of the autoscaled trace plotter: sample ring, control, min/max scan, output.
//
// Items are accepted one per cycle while o_busy is low; samples go into a 64-entry ring
// RAM. An item with final_item set hands over to the plot run and raises o_busy: one
// RAM pass over the kept samples finds the limits and a widen step widens a flat series;
// then each kept point goes through RAM read, launch, 6-step shift-add multiply,
// rounding step, 14-step restoring divide and output, and o_busy stays high until
// the last point's result. Each result shows for exactly one cycle on o_result_valid
// and cannot be held off; the next transaction may be accepted in the cycle the last
// result shows. A final item on an empty log gives its single result the next cycle
// without raising o_busy.
module autoscaled_trace_plotter
    import atp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                      i_sample_valid,
    input  logic                      i_final_item,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [ROW_W-1:0]          i_cfg_data,
    output logic                      o_result_valid,
    output logic [ROW_W-1:0]          o_column,
    output logic [ROW_W-1:0]          o_row,
    output logic                      o_first_point,
    output logic signed [LIMIT_W-1:0] o_scale_low,
    output logic signed [LIMIT_W-1:0] o_scale_high,
    output logic                      o_log_empty,
    output logic                      o_run_end
);

    t_ctl_state r_state, n_state;

    logic [ROW_W-1:0]          r_top;
    logic [ROW_W-1:0]          r_bottom;
    logic [AW-1:0]             r_wp;
    logic [CW-1:0]             r_kept;
    logic [CW-1:0]             r_n;
    logic [AW-1:0]             r_start_addr;
    logic [AW-1:0]             r_rd_addr;
    logic [CW-1:0]             r_issue;
    logic [CW-1:0]             r_c;
    logic                      r_dvld;
    logic signed [LIMIT_W-1:0] r_min;
    logic signed [LIMIT_W-1:0] r_max;

    logic                      r_out_valid;
    logic [ROW_W-1:0]          r_column;
    logic [ROW_W-1:0]          r_row;
    logic                      r_first;
    logic signed [LIMIT_W-1:0] r_low;
    logic signed [LIMIT_W-1:0] r_high;
    logic                      r_empty;
    logic                      r_end;

    logic                      w_acc;
    logic [AW-1:0]             w_wp_inc;
    logic [AW-1:0]             w_wp_after;
    logic [CW-1:0]             w_kept_after;
    logic [CW:0]               w_start_raw;
    logic [AW-1:0]             w_start;
    logic [AW-1:0]             w_rd_next;
    logic                      w_issue;
    logic                      w_scan_end;
    logic                      w_launch;
    logic                      w_last_pt;
    logic [SAMPLE_W-1:0]       w_rdata;
    logic signed [LIMIT_W-1:0] w_value;
    logic signed [LIMIT_W-1:0] w_diff;
    logic signed [LIMIT_W-1:0] w_span;
    logic signed [HEIGHT_W-1:0] w_height;
    logic [7:0]                w_col_full;
    logic                      w_scl_done;
    logic [ROW_W-1:0]          w_scl_row;

    assign w_acc        = i_start && !o_busy;
    assign w_wp_inc     = (r_wp == AW'(WIDTH - 1)) ? '0 : r_wp + 1'b1;
    assign w_wp_after   = i_sample_valid ? w_wp_inc : r_wp;
    assign w_kept_after = (i_sample_valid && (r_kept < CW'(WIDTH))) ? r_kept + 1'b1 : r_kept;
    assign w_start_raw  = (CW+1)'(w_wp_after) + (CW+1)'(WIDTH) - (CW+1)'(w_kept_after);
    assign w_start      = (w_start_raw >= (CW+1)'(WIDTH)) ? AW'(w_start_raw - (CW+1)'(WIDTH))
                                                          : AW'(w_start_raw);
    assign w_rd_next    = (r_rd_addr == AW'(WIDTH - 1)) ? '0 : r_rd_addr + 1'b1;
    assign w_last_pt    = (r_c == r_n - 1'b1);
    assign w_value      = LIMIT_W'(signed'(w_rdata));
    assign w_diff       = w_value - r_min;
    assign w_span       = r_max - r_min;
    assign w_height     = signed'({1'b0, r_bottom}) - signed'({1'b0, r_top});
    assign w_col_full   = 8'(WIDTH) - 8'(r_n) + 8'(r_c);

    atp_ram #(
        .DW    (SAMPLE_W),
        .DEPTH (WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && i_sample_valid),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    atp_scaler u_scaler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_launch),
        .i_diff   (w_diff[DIFF_W-1:0]),
        .i_height (w_height),
        .i_span   (w_span[DIFF_W-1:0]),
        .i_bottom (r_bottom),
        .o_done   (w_scl_done),
        .o_row    (w_scl_row)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_acc && i_final_item && (w_kept_after != '0)) n_state = ST_SCAN;
            ST_SCAN:   if (w_scan_end) n_state = ST_WIDEN;
            ST_WIDEN:  n_state = ST_READ;
            ST_READ:   n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_CALC;
            ST_CALC:   if (w_scl_done) n_state = w_last_pt ? ST_IDLE : ST_READ;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy     = 1'b1;
        w_issue    = 1'b0;
        w_scan_end = 1'b0;
        w_launch   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
            end
            ST_SCAN: begin
                w_issue    = (r_issue != r_n);
                w_scan_end = (r_issue == r_n) && !r_dvld;
            end
            ST_LAUNCH: begin
                w_launch = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_top       <= TOP_RESET;
            r_bottom    <= BOTTOM_RESET;
            r_wp        <= '0;
            r_kept      <= '0;
            r_dvld      <= 1'b0;
            r_min       <= MIN_INIT;
            r_max       <= MAX_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            r_dvld      <= w_issue;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TOP_ROW:    r_top    <= i_cfg_data;
                    REG_BOTTOM_ROW: r_bottom <= i_cfg_data;
                    default:        r_top    <= r_top;
                endcase
            end

            if (w_acc) begin
                if (!i_final_item) begin
                    r_wp   <= w_wp_after;
                    r_kept <= w_kept_after;
                end else begin
                    r_wp   <= '0;
                    r_kept <= '0;
                    if (w_kept_after == '0) begin
                        r_out_valid <= 1'b1;
                        r_column    <= '0;
                        r_row       <= '0;
                        r_first     <= 1'b0;
                        r_low       <= '0;
                        r_high      <= '0;
                        r_empty     <= 1'b1;
                        r_end       <= 1'b1;
                    end else begin
                        r_n          <= w_kept_after;
                        r_start_addr <= w_start;
                        r_rd_addr    <= w_start;
                        r_issue      <= '0;
                        r_min        <= MIN_INIT;
                        r_max        <= MAX_INIT;
                    end
                end
            end

            if (w_issue) begin
                r_rd_addr <= w_rd_next;
                r_issue   <= r_issue + 1'b1;
            end
            if (r_state == ST_SCAN && r_dvld) begin
                if (w_value < r_min) r_min <= w_value;
                if (w_value > r_max) r_max <= w_value;
            end

            if (r_state == ST_WIDEN) begin
                r_rd_addr <= r_start_addr;
                r_c       <= '0;
                if (r_min == r_max) begin
                    r_min <= r_min - 1'b1;
                    r_max <= r_max + 1'b1;
                end
            end

            if (r_state == ST_CALC && w_scl_done) begin
                r_out_valid <= 1'b1;
                r_column    <= w_col_full[ROW_W-1:0];
                r_row       <= w_scl_row;
                r_first     <= (r_c == '0);
                r_low       <= r_min;
                r_high      <= r_max;
                r_empty     <= 1'b0;
                r_end       <= w_last_pt;
                r_c         <= r_c + 1'b1;
                r_rd_addr   <= w_rd_next;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_column       = r_column;
    assign o_row          = r_row;
    assign o_first_point  = r_first;
    assign o_scale_low    = r_low;
    assign o_scale_high   = r_high;
    assign o_log_empty    = r_empty;
    assign o_run_end      = r_end;

endmodule
